>>> hdl/swsd_pkg.sv
// Shared constants and types for the moving-window standard deviation block.
package swsd_pkg;

	localparam int WINDOW   = 50;
	localparam int SAMPLE_W = 16;
	localparam int SLOT_W   = $clog2(WINDOW);
	localparam int CNT_W    = $clog2(WINDOW + 1);
	localparam int SUM_W    = SAMPLE_W + $clog2(WINDOW);
	localparam int SQS_W    = 2 * SAMPLE_W + $clog2(WINDOW);
	localparam int PROD_W   = SQS_W + CNT_W;
	localparam int NSQ_W    = 2 * CNT_W;
	localparam int VAR_W    = 2 * SAMPLE_W;
	localparam int STEP_W   = $clog2(VAR_W);

	// window statistics handed to the serial arithmetic unit
	typedef struct packed {
		logic [CNT_W-1:0] n;
		logic [SUM_W-1:0] sum;
		logic [SQS_W-1:0] sumsq;
	} calc_req_t;

endpackage

>>> hdl/swsd_ram.sv
// Generic single-port-write, registered-read RAM.
module swsd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> hdl/swsd_calc.sv
// Serial arithmetic: shift-add products, restoring divide by n^2, digit-by-digit square root.
module swsd_calc
	import swsd_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  calc_req_t           req,
	output logic                done,
	output logic [SAMPLE_W-1:0] root
);

	typedef enum logic [4:0] {
		C_IDLE = 5'b00001,
		C_MUL  = 5'b00010,
		C_SUB  = 5'b00100,
		C_DIV  = 5'b01000,
		C_ROOT = 5'b10000
	} calc_state_t;

	calc_state_t state_q;
	logic [STEP_W-1:0]   step_q;
	logic                done_q;

	logic [PROD_W-1:0]   mc_a_q, mc_b_q, acc_a_q, acc_b_q;
	logic [CNT_W-1:0]    mp_a_q;
	logic [SUM_W-1:0]    mp_b_q;
	logic [NSQ_W-1:0]    nsq_q;
	logic [NSQ_W-1:0]    rem_q;
	logic [VAR_W-1:0]    quo_q;
	logic [SAMPLE_W:0]   srem_q;
	logic [SAMPLE_W-1:0] root_q;

	logic [PROD_W-1:0]   num_d;
	logic [NSQ_W:0]      dtrial;
	logic                dge;
	logic [SAMPLE_W+2:0] srr, strial;
	logic                sge;

	always_comb begin
		num_d  = (acc_a_q > acc_b_q) ? acc_a_q - acc_b_q : '0;
		dtrial = {rem_q, quo_q[VAR_W-1]};
		dge    = dtrial >= {1'b0, nsq_q};
		srr    = {srem_q, quo_q[VAR_W-1 -: 2]};
		strial = {1'b0, root_q, 2'b01};
		sge    = srr >= strial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			step_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				C_IDLE: begin
					if (start) begin
						state_q <= C_MUL;
						step_q  <= '0;
					end
				end
				C_MUL: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(SUM_W - 1)) begin
						state_q <= C_SUB;
					end
				end
				C_SUB: begin
					state_q <= C_DIV;
					step_q  <= '0;
				end
				C_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(VAR_W - 1)) begin
						state_q <= C_ROOT;
						step_q  <= '0;
					end
				end
				C_ROOT: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(SAMPLE_W - 1)) begin
						state_q <= C_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	// datapath: n*sumsq and sum*sum run side by side, one multiplier bit per cycle
	always_ff @(posedge clk) begin
		unique case (state_q)
			C_IDLE: begin
				mc_a_q  <= PROD_W'(req.sumsq);
				mp_a_q  <= req.n;
				mc_b_q  <= PROD_W'(req.sum);
				mp_b_q  <= req.sum;
				acc_a_q <= '0;
				acc_b_q <= '0;
				nsq_q   <= NSQ_W'(req.n) * NSQ_W'(req.n);
			end
			C_MUL: begin
				if (mp_a_q[0]) begin
					acc_a_q <= acc_a_q + mc_a_q;
				end
				if (mp_b_q[0]) begin
					acc_b_q <= acc_b_q + mc_b_q;
				end
				mc_a_q <= mc_a_q << 1;
				mc_b_q <= mc_b_q << 1;
				mp_a_q <= mp_a_q >> 1;
				mp_b_q <= mp_b_q >> 1;
			end
			C_SUB: begin
				// variance fits VAR_W bits, so the high part is already below n^2
				rem_q <= NSQ_W'(num_d >> VAR_W);
				quo_q <= num_d[VAR_W-1:0];
			end
			C_DIV: begin
				rem_q  <= dge ? NSQ_W'(dtrial - {1'b0, nsq_q}) : dtrial[NSQ_W-1:0];
				quo_q  <= {quo_q[VAR_W-2:0], dge};
				srem_q <= '0;
				root_q <= '0;
			end
			C_ROOT: begin
				// quotient shifts out two bits per step as the radicand
				srem_q <= sge ? (SAMPLE_W+1)'(srr - strial) : srr[SAMPLE_W:0];
				root_q <= {root_q[SAMPLE_W-2:0], sge};
				quo_q  <= quo_q << 2;
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign root = root_q;

endmodule

>>> hdl/sliding_window_std_deviation.sv
// Top level: sample ring, running sums, sequencing and output register.
//
//  channel  dir  fields (lsb up)          accepted when
//  s_*      in   tdata[15:0] sample       s_tvalid & s_tready
//  m_*      out  tdata[15:0] std_dev      m_tvalid & m_tready
//
// A word passes from acceptance to result through the ring read and sum update,
// the start of the arithmetic unit, the bit-serial products, a subtract, the
// restoring divide by n^2, the square root, capture of the root and the load
// of the output register. With fewer than two samples held the arithmetic
// unit is skipped and the result is zero.
// Reset clears control, count, slot and sums; ring contents are not cleared.
// A new word is taken while a result waits in the output register.
module sliding_window_std_deviation
	import swsd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] sample
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // [15:0] std_deviation
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_RD   = 5'b00010,
		ST_UPD  = 5'b00100,
		ST_CALC = 5'b01000,
		ST_HOLD = 5'b10000
	} state_t;

	state_t state_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [CNT_W-1:0]    count_q;
	logic [SUM_W-1:0]    sum_q;
	logic [SQS_W-1:0]    sumsq_q;
	logic [SAMPLE_W-1:0] sample_q, old_q, res_q;
	logic [VAR_W-1:0]    old_sq_q, new_sq_q;
	logic                start_q;
	logic                m_tvalid_q;
	logic [SAMPLE_W-1:0] m_tdata_q;

	logic                accept, full, out_load;
	logic [CNT_W-1:0]    count_d;
	logic [SAMPLE_W-1:0] ram_rdata;
	calc_req_t           calc_req;
	logic                calc_done;
	logic [SAMPLE_W-1:0] calc_root;

	assign s_tready = state_q == ST_IDLE;
	assign accept   = s_tvalid && s_tready;
	assign full     = count_q == CNT_W'(WINDOW);
	assign count_d  = full ? count_q : count_q + 1'b1;
	assign out_load = (state_q == ST_HOLD) && (!m_tvalid_q || m_tready);

	assign calc_req.n     = count_q;
	assign calc_req.sum   = sum_q;
	assign calc_req.sumsq = sumsq_q;

	swsd_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(WINDOW)
	) u_ring (
		.clk   (clk),
		.we    (state_q == ST_RD),
		.waddr (slot_q),
		.wdata (sample_q),
		.re    (accept),
		.raddr (slot_q),
		.rdata (ram_rdata)
	);

	swsd_calc u_calc (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.req    (calc_req),
		.done   (calc_done),
		.root   (calc_root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			slot_q     <= '0;
			count_q    <= '0;
			sum_q      <= '0;
			sumsq_q    <= '0;
			start_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_RD;
					end
				end
				ST_RD: state_q <= ST_UPD;
				ST_UPD: begin
					sum_q   <= sum_q - SUM_W'(old_q) + SUM_W'(sample_q);
					sumsq_q <= sumsq_q - SQS_W'(old_sq_q) + SQS_W'(new_sq_q);
					count_q <= count_d;
					slot_q  <= (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + 1'b1;
					if (count_d < CNT_W'(2)) begin
						state_q <= ST_HOLD;
					end else begin
						state_q <= ST_CALC;
						start_q <= 1'b1;
					end
				end
				ST_CALC: begin
					if (calc_done) begin
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= s_tdata[SAMPLE_W-1:0];
		end
		if (state_q == ST_RD) begin
			// oldest sample leaves the sums only once the window is full
			old_q    <= full ? ram_rdata : '0;
			old_sq_q <= full ? VAR_W'(ram_rdata) * VAR_W'(ram_rdata) : '0;
			new_sq_q <= VAR_W'(sample_q) * VAR_W'(sample_q);
		end
		if (state_q == ST_UPD) begin
			res_q <= '0;
		end else if (state_q == ST_CALC && calc_done) begin
			res_q <= calc_root;
		end
		if (out_load) begin
			m_tdata_q <= res_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(WINDOW))
		else $error("held count beyond window");

	a_accept_reads: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_RD)
		else $error("accepted word did not start a ring read");

	a_done_in_calc: assert property (@(posedge clk) disable iff (!arst_n)
		calc_done |-> state_q == ST_CALC)
		else $error("arithmetic unit finished outside calc state");

	a_small_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && count_q < CNT_W'(2)) |-> m_tdata == '0)
		else $error("nonzero result with fewer than two samples");
`endif

endmodule
